// ----- rtl/mlft_pkg.sv -----
package mlft_pkg;

    localparam int MAC_W          = 48;
    localparam int PORT_W         = 4;
    localparam int MASK_W         = 16;
    localparam int ENTRIES_DEFAULT = 16;
    localparam int PORTS_DEFAULT  = 16;

    localparam logic ACT_LEARN   = 1'b0;
    localparam logic ACT_FORWARD = 1'b1;

endpackage

// ----- rtl/mlft_ram.sv -----
module mlft_ram
    import mlft_pkg::*;
#(
    parameter int WIDTH  = MAC_W + PORT_W,
    parameter int DEPTH  = ENTRIES_DEFAULT,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mac_learning_forward_table.sv -----
// mac address table with source learning and destination lookup
// a result is loaded once the linear scan of the entry ram that follows acceptance ends and the
// output register is free, one entry read per cycle, a hit ends the scan early
// one item at a time; the next item is taken in the cycle after the result is loaded,
// and is taken while the result waits in the output register
// rst_n is asynchronous active low: clears entry count, enable mask and control state;
// entry ram contents stay undefined until written
module mac_learning_forward_table
    import mlft_pkg::*;
#(
    parameter int TABLE_ENTRIES = ENTRIES_DEFAULT,
    parameter int NUM_PORTS     = PORTS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              action,
    input  logic [MAC_W-1:0]  mac_address,
    input  logic [PORT_W-1:0] ingress_port,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              hit,
    output logic              learned,
    output logic              table_full,
    output logic [PORT_W-1:0] egress_port,
    output logic [MASK_W-1:0] egress_mask,
    input  logic              cfg_wr_en,
    input  logic [MASK_W-1:0] cfg_wr_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int ENT_W = MAC_W + PORT_W;
    localparam logic [MASK_W-1:0] LIMIT_MASK = (NUM_PORTS >= MASK_W) ? {MASK_W{1'b1}}
                                             : MASK_W'((64'd1 << NUM_PORTS) - 64'd1);

    typedef enum logic [2:0]
    {
        ST_IDLE    = 3'b001,
        ST_SCAN    = 3'b010,
        ST_RESOLVE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              found_reg, found_next;
    logic [PORT_W-1:0] fport_reg, fport_next;
    logic [MASK_W-1:0] enable_reg;

    logic              act_reg;
    logic [MAC_W-1:0]  mac_reg;
    logic [PORT_W-1:0] iport_reg;

    logic              out_valid_reg, out_valid_next;
    logic              hit_reg, learned_reg, full_reg;
    logic [PORT_W-1:0] eport_reg;
    logic [MASK_W-1:0] emask_reg;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ENT_W-1:0]  ram_rdata;
    logic [MAC_W-1:0]  rd_mac;
    logic [PORT_W-1:0] rd_port;

    logic              accept;
    logic              load_out;
    logic              is_full;
    logic              res_learned;
    logic              res_full;
    logic [PORT_W-1:0] res_eport;
    logic [MASK_W-1:0] res_emask;

    assign rd_mac  = ram_rdata[MAC_W-1:0];
    assign rd_port = ram_rdata[ENT_W-1:MAC_W];

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign is_full  = (count_reg == CNT_W'(TABLE_ENTRIES));
    assign load_out = (state_reg == ST_RESOLVE) && (!out_valid_reg || out_ready);

    mlft_ram #(
        .WIDTH  (ENT_W),
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({iport_reg, mac_reg}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        fport_next = fport_reg;
        ram_raddr  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    fport_next = '0;
                    state_next = (count_reg == '0) ? ST_RESOLVE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_mac == mac_reg)
                begin
                    found_next = 1'b1;
                    fport_next = rd_port;
                    state_next = ST_RESOLVE;
                end
                else if ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg)
                begin
                    state_next = ST_RESOLVE;
                end
                else
                begin
                    idx_next  = idx_reg + IDX_W'(1);
                    ram_raddr = idx_reg + IDX_W'(1);
                end
            end
            ST_RESOLVE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_learned = 1'b0;
        res_full    = 1'b0;
        res_eport   = '0;
        res_emask   = '0;
        if (act_reg == ACT_LEARN)
        begin
            res_learned = !found_reg && !is_full;
            res_full    = !found_reg && is_full;
        end
        else if (found_reg)
        begin
            res_eport = fport_reg;
            res_emask = (MASK_W'(1) << fport_reg) & LIMIT_MASK;
        end
        else
        begin
            res_emask = enable_reg & LIMIT_MASK;
        end
    end

    assign ram_we     = load_out && res_learned;
    assign count_next = ram_we ? count_reg + CNT_W'(1) : count_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            fport_reg     <= '0;
            enable_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            fport_reg     <= fport_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                enable_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= action;
            mac_reg   <= mac_address;
            iport_reg <= ingress_port;
        end
        if (load_out)
        begin
            hit_reg     <= found_reg;
            learned_reg <= res_learned;
            full_reg    <= res_full;
            eport_reg   <= res_eport;
            emask_reg   <= res_emask;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign learned     = learned_reg;
    assign table_full  = full_reg;
    assign egress_port = eport_reg;
    assign egress_mask = emask_reg;

endmodule

// ----- rtl/mlft_checker.sv -----
module mlft_checker
    import mlft_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              hit,
    input logic              learned,
    input logic              table_full,
    input logic [PORT_W-1:0] egress_port,
    input logic [MASK_W-1:0] egress_mask
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({hit, learned, table_full, egress_port, egress_mask}))
        else $error("stalled result changed");

    // one item in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while busy");

    // status flags exclude each other
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && learned) && !(hit && table_full) && !(learned && table_full))
        else $error("conflicting status flags");

    // learn outcome carries no egress
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (learned || table_full) |-> egress_port == '0 && egress_mask == '0)
        else $error("learn result with egress");

    // egress port only on a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> egress_port == '0)
        else $error("egress port without hit");

endmodule

bind mac_learning_forward_table mlft_checker u_mlft_checker (.*);
